FILE: sv/kvt_pkg.sv
`default_nettype none

package kvt_pkg;

	// Table geometry and field widths
	localparam int DEPTH_DEF = 64;
	localparam int KEY_W     = 8;
	localparam int VAL_W     = 32;
	localparam int OP_W      = 3;
	localparam int STAT_W    = 2;

	// Request opcodes
	typedef enum logic [OP_W-1:0] {
		OP_APPEND    = 3'd0,
		OP_FIND_KEY  = 3'd1,
		OP_FIND_VAL  = 3'd2,
		OP_EXISTS    = 3'd3,
		OP_REMOVE    = 3'd4,
		OP_DEDUPE    = 3'd5,
		OP_DUMP      = 3'd6,
		OP_NOP       = 3'd7
	} op_t;

	// Result status codes
	typedef enum logic [STAT_W-1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic shift;  // advance the active region one place toward the head
		logic feed;   // tail cell takes the write data during a shift
		logic mark;   // fed entry is flagged as kept (dedupe)
		logic wr;     // append: addressed cell takes the write data
		logic clr;    // clear all kept flags
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/kvt_cell.sv
`default_nettype none

module kvt_cell
	import kvt_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctl_t        ctl,
	input  wire logic             below_tail,
	input  wire logic             at_tail,
	input  wire logic             at_append,
	input  wire logic [KEY_W-1:0] nb_key,
	input  wire logic [VAL_W-1:0] nb_value,
	input  wire logic             nb_kept,
	input  wire logic [KEY_W-1:0] wr_key,
	input  wire logic [VAL_W-1:0] wr_value,
	input  wire logic [KEY_W-1:0] cmp_key,
	input  wire logic [VAL_W-1:0] cmp_value,
	output logic [KEY_W-1:0]      cell_key,
	output logic [VAL_W-1:0]      cell_value,
	output logic                  cell_kept,
	output logic                  kept_match
);

	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic             kept_q;

	// Load entry from append, from the neighbor, or from the tail feed
	always_ff @(posedge clk) begin
		if (ctl.wr && at_append) begin
			key_q   <= wr_key;
			value_q <= wr_value;
		end else if (ctl.shift && below_tail) begin
			key_q   <= nb_key;
			value_q <= nb_value;
		end else if (ctl.shift && at_tail && ctl.feed) begin
			key_q   <= wr_key;
			value_q <= wr_value;
		end
	end

	// Track the kept flag along with the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kept_q <= 1'b0;
		end else if (ctl.clr) begin
			kept_q <= 1'b0;
		end else if (ctl.shift && below_tail) begin
			kept_q <= nb_kept;
		end else if (ctl.shift && at_tail) begin
			kept_q <= ctl.feed & ctl.mark;
		end
	end

	// Compare a kept entry against the head pair
	assign kept_match = kept_q && (key_q == cmp_key) && (value_q == cmp_value);
	assign cell_key   = key_q;
	assign cell_value = value_q;
	assign cell_kept  = kept_q;

endmodule

`default_nettype wire

FILE: sv/key_value_table_linear_match.sv
`default_nettype none

// Ordered table of up to DEPTH (key, value) pairs kept in a chain of cells, oldest entry
// at the head. An append writes the next free cell, then loads its result. Every other
// request but a no-op walks a non-empty table: the occupied cells rotate one place per
// cycle past the head, where the entry is compared, kept or dropped, so a request visits
// each of the count stored entries once, count being at most DEPTH.
// A dump emits one result per entry per cycle and pauses while the output is stalled.
// Dedupe compares the head against all entries already kept in parallel, so its walk
// also visits each entry once. A new request is accepted once the previous one has placed
// its final result in the output register.
module key_value_table_linear_match
	import kvt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [OP_W-1:0]   opcode,
	input  wire logic [KEY_W-1:0]  key,
	input  wire logic signed [VAL_W-1:0] value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [STAT_W-1:0]      status,
	output logic [KEY_W-1:0]       out_key,
	output logic signed [VAL_W-1:0] out_value,
	output logic                   last
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH
	} state_t;

	state_t           state_q;
	logic [CW-1:0]    count_q;
	logic [CW-1:0]    len_q;
	logic [CW-1:0]    steps_q;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] value_q;
	logic             hit_q;
	logic [KEY_W-1:0] hit_key_q;
	logic [VAL_W-1:0] hit_value_q;
	logic             full_q;

	logic             out_valid_q;
	status_t          status_q;
	logic [KEY_W-1:0] out_key_q;
	logic [VAL_W-1:0] out_value_q;
	logic             last_q;

	cell_ctl_t        ctl;
	logic [KEY_W-1:0] cell_key   [DEPTH];
	logic [VAL_W-1:0] cell_value [DEPTH];
	logic             cell_kept  [DEPTH];
	logic [DEPTH-1:0] match_vec;
	logic [KEY_W-1:0] wr_key;
	logic [VAL_W-1:0] wr_value;

	logic             accept;
	op_t              in_op;
	logic             full;
	logic             walk_op;
	logic             km;
	logic             vm;
	logic             hit_now;
	logic             dup;
	logic             out_free;
	logic             out_load;
	logic             step_go;
	logic             drop;
	logic             lookup_op;

	// Request decode
	assign in_op    = op_t'(opcode);
	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign full     = (count_q == CW'(DEPTH));
	assign walk_op  = (in_op == OP_FIND_KEY) || (in_op == OP_FIND_VAL) ||
		(in_op == OP_EXISTS) || (in_op == OP_REMOVE) || (in_op == OP_DEDUPE) ||
		(in_op == OP_DUMP);
	assign lookup_op = (op_q == OP_FIND_KEY) || (op_q == OP_FIND_VAL) ||
		(op_q == OP_EXISTS) || (op_q == OP_REMOVE);

	// Compare the head entry against the request
	assign km  = (cell_key[0] == key_q);
	assign vm  = (cell_value[0] == value_q);
	assign dup = |match_vec;

	always_comb begin
		case (op_q)
			OP_FIND_KEY: hit_now = km;
			OP_FIND_VAL: hit_now = vm;
			OP_EXISTS:   hit_now = km && vm;
			OP_REMOVE:   hit_now = km;
			default:     hit_now = 1'b0;
		endcase
	end

	// Advance one entry per cycle; a dump waits for room at the output
	assign out_free = !out_valid_q || out_ready;
	assign step_go  = (state_q == S_WALK) && ((op_q != OP_DUMP) || out_free);
	assign drop     = step_go && (((op_q == OP_REMOVE) && km && !hit_q) ||
		((op_q == OP_DEDUPE) && dup));

	// Load the output register with a dump entry or a final result
	assign out_load = (step_go && (op_q == OP_DUMP)) || ((state_q == S_FINISH) && out_free);

	always_comb begin
		ctl.shift = step_go;
		ctl.feed  = !drop;
		ctl.mark  = (op_q == OP_DEDUPE);
		ctl.wr    = accept && (in_op == OP_APPEND) && !full;
		ctl.clr   = accept;
	end

	// Append writes the request pair; a walk feeds the head back to the tail
	assign wr_key   = (state_q == S_IDLE) ? key : cell_key[0];
	assign wr_value = (state_q == S_IDLE) ? value : cell_value[0];

	// Cell chain
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] nb_key;
		logic [VAL_W-1:0] nb_value;
		logic             nb_kept;

		if (i == DEPTH - 1) begin : g_end
			assign nb_key   = wr_key;
			assign nb_value = wr_value;
			assign nb_kept  = 1'b0;
		end else begin : g_mid
			assign nb_key   = cell_key[i+1];
			assign nb_value = cell_value[i+1];
			assign nb_kept  = cell_kept[i+1];
		end

		kvt_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.below_tail (CW'(i + 1) < len_q),
			.at_tail    (CW'(i + 1) == len_q),
			.at_append  (CW'(i) == count_q),
			.nb_key     (nb_key),
			.nb_value   (nb_value),
			.nb_kept    (nb_kept),
			.wr_key     (wr_key),
			.wr_value   (wr_value),
			.cmp_key    (cell_key[0]),
			.cmp_value  (cell_value[0]),
			.cell_key   (cell_key[i]),
			.cell_value (cell_value[i]),
			.cell_kept  (cell_kept[i]),
			.kept_match (match_vec[i])
		);
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			len_q       <= '0;
			steps_q     <= '0;
			op_q        <= OP_NOP;
			key_q       <= '0;
			value_q     <= '0;
			hit_q       <= 1'b0;
			hit_key_q   <= '0;
			hit_value_q <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			out_key_q   <= '0;
			out_value_q <= '0;
			last_q      <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= in_op;
						key_q   <= key;
						value_q <= value;
						hit_q   <= 1'b0;
						len_q   <= count_q;
						steps_q <= count_q;
						full_q  <= full;
						if (in_op == OP_APPEND) begin
							if (!full) begin
								count_q <= count_q + CW'(1);
							end
							state_q <= S_FINISH;
						end else if (walk_op && (count_q != '0)) begin
							state_q <= S_WALK;
						end else begin
							state_q <= S_FINISH;
						end
					end
				end
				S_WALK: begin
					if (step_go) begin
						steps_q <= steps_q - CW'(1);
						if (hit_now && !hit_q) begin
							hit_q       <= 1'b1;
							hit_key_q   <= cell_key[0];
							hit_value_q <= cell_value[0];
						end
						if (drop) begin
							len_q <= len_q - CW'(1);
						end
						if (op_q == OP_DUMP) begin
							status_q    <= ST_OK;
							out_key_q   <= cell_key[0];
							out_value_q <= cell_value[0];
							last_q      <= (steps_q == CW'(1));
						end
						if (steps_q == CW'(1)) begin
							state_q <= (op_q == OP_DUMP) ? S_IDLE : S_FINISH;
						end
					end
				end
				S_FINISH: begin
					if (out_free) begin
						if ((op_q == OP_REMOVE) || (op_q == OP_DEDUPE)) begin
							count_q <= len_q;
						end
						last_q      <= 1'b1;
						out_key_q   <= (lookup_op && hit_q) ? hit_key_q : '0;
						out_value_q <= (lookup_op && hit_q) ? hit_value_q : '0;
						if (op_q == OP_APPEND) begin
							status_q <= full_q ? ST_FULL : ST_OK;
						end else if (op_q == OP_DEDUPE) begin
							status_q <= ST_OK;
						end else if (lookup_op && hit_q) begin
							status_q <= ST_OK;
						end else begin
							status_q <= ST_MISS;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign out_key   = out_key_q;
	assign out_value = out_value_q;
	assign last      = last_q;

	// Fill level never exceeds the table
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above table depth");

	// Unvisited entries fit in the working region, which fits in the table
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WALK) |-> ((steps_q != '0) && (steps_q <= len_q) && (len_q <= count_q)))
		else $error("walk counters out of order");

	// Lookups and dumps never shrink the working region
	a_walk_keep: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WALK) && (op_q != OP_REMOVE) && (op_q != OP_DEDUPE)) |->
		(len_q == count_q))
		else $error("non-removing walk dropped an entry");

	// A remove drops exactly the first matching entry
	a_remove_once: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_WALK) && (op_q == OP_REMOVE)) |->
		(({1'b0, len_q} + (CW+1)'(hit_q)) == {1'b0, count_q}))
		else $error("remove dropped a wrong number of entries");

endmodule

`default_nettype wire

FILE: tb/sv/key_value_table_linear_match_tb.sv
`default_nettype none

module key_value_table_linear_match_tb
	import kvt_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = DEPTH_DEF;
	localparam int HOLD_CYCLES = 300;
	localparam int NUM_PHASES = 5;
	localparam int DIR_ROWS = 25;

	// idle percentages, request count, table-fill bias and pressure per random phase
	localparam int PH_TX_IDLE [NUM_PHASES] = '{0, 64, 0, 20, 0};
	localparam int PH_RX_STALL [NUM_PHASES] = '{0, 0, 64, 20, 0};
	localparam int PH_COUNT [NUM_PHASES] = '{75, 35, 35, 35, 15};
	localparam bit PH_FILL [NUM_PHASES] = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
	localparam bit PH_HOLD [NUM_PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

	typedef struct {
		status_t                  status;
		logic [KEY_W-1:0]         key;
		logic signed [VAL_W-1:0]  value;
		logic                     last;
	} kv_result_t;

	typedef struct {
		op_t                      op;
		logic [KEY_W-1:0]         key;
		logic signed [VAL_W-1:0]  value;
		bit                       typed;
		status_t                  status;
	} stim_row_t;

	// Directed requests; typed rows expect one result with zero key and value
	stim_row_t directed_rows [DIR_ROWS] = '{
		'{OP_DUMP,     8'h00, 32'sh00000000, 1'b1, ST_MISS},
		'{OP_FIND_KEY, 8'h00, 32'sh00000000, 1'b1, ST_MISS},
		'{OP_EXISTS,   8'h00, 32'sh00000000, 1'b1, ST_MISS},
		'{OP_REMOVE,   8'h00, 32'sh00000000, 1'b1, ST_MISS},
		'{OP_DEDUPE,   8'h00, 32'sh00000000, 1'b1, ST_OK},
		'{OP_NOP,      8'hff, 32'shffffffff, 1'b1, ST_MISS},
		'{OP_APPEND,   8'h00, 32'sh00000000, 1'b1, ST_OK},
		'{OP_APPEND,   8'hff, 32'sh7fffffff, 1'b1, ST_OK},
		'{OP_APPEND,   8'hff, 32'sh80000000, 1'b1, ST_OK},
		'{OP_APPEND,   8'h5a, 32'shffffffff, 1'b1, ST_OK},
		'{OP_APPEND,   8'hff, 32'sh7fffffff, 1'b1, ST_OK},
		'{OP_APPEND,   8'h00, 32'sh00000000, 1'b1, ST_OK},
		'{OP_FIND_KEY, 8'hff, 32'sh00000000, 1'b0, ST_OK},
		'{OP_FIND_VAL, 8'h00, 32'sh80000000, 1'b0, ST_OK},
		'{OP_FIND_VAL, 8'h00, 32'sh0000a5a5, 1'b0, ST_OK},
		'{OP_EXISTS,   8'hff, 32'sh80000000, 1'b0, ST_OK},
		'{OP_EXISTS,   8'h5a, 32'sh00000000, 1'b0, ST_OK},
		'{OP_DUMP,     8'h00, 32'sh00000000, 1'b0, ST_OK},
		'{OP_DEDUPE,   8'h00, 32'sh00000000, 1'b0, ST_OK},
		'{OP_DUMP,     8'h00, 32'sh00000000, 1'b0, ST_OK},
		'{OP_REMOVE,   8'hff, 32'sh00000000, 1'b0, ST_OK},
		'{OP_REMOVE,   8'h33, 32'sh00000000, 1'b1, ST_MISS},
		'{OP_NOP,      8'h00, 32'sh00000000, 1'b1, ST_MISS},
		'{OP_REMOVE,   8'h00, 32'sh00000000, 1'b0, ST_OK},
		'{OP_DUMP,     8'h00, 32'sh00000000, 1'b0, ST_OK}
	};

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic [OP_W-1:0]           opcode = '0;
	logic [KEY_W-1:0]          key = '0;
	logic signed [VAL_W-1:0]   value = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [STAT_W-1:0]         status;
	logic [KEY_W-1:0]          out_key;
	logic signed [VAL_W-1:0]   out_value;
	logic                      last;

	// Predicted table contents
	logic [KEY_W-1:0]          tbl_key [DEPTH];
	logic signed [VAL_W-1:0]   tbl_val [DEPTH];
	int                        tbl_count = 0;

	kv_result_t                expected_results [$];
	int                        fail_count = 0;
	int                        results_checked = 0;
	int                        requests_sent = 0;
	int                        full_refusals = 0;
	int                        largest_dump = 0;
	int                        tx_idle_pct = 0;
	int                        rx_stall_pct = 0;
	bit                        hold_toggle = 1'b0;

	key_value_table_linear_match #(
		.DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.key(key),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.out_key(out_key),
		.out_value(out_value),
		.last(last)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("key_value_table_linear_match_tb: FAIL");
		$finish;
	end

	// Apply one request to the predicted table and collect the results it causes
	task automatic predict_table(input op_t op, input logic [KEY_W-1:0] k,
			input logic signed [VAL_W-1:0] v, ref kv_result_t res [$]);
		int found;
		int kept;
		bit dup;
		found = -1;
		res.delete();
		case (op)
		OP_APPEND: begin
			if (tbl_count >= DEPTH) begin
				res.push_back('{ST_FULL, '0, '0, 1'b1});
			end else begin
				tbl_key[tbl_count] = k;
				tbl_val[tbl_count] = v;
				tbl_count++;
				res.push_back('{ST_OK, '0, '0, 1'b1});
			end
		end
		OP_FIND_KEY, OP_FIND_VAL, OP_EXISTS, OP_REMOVE: begin
			// first match from the oldest entry
			for (int i = 0; i < tbl_count && found < 0; i++)
				if (op == OP_FIND_VAL ? tbl_val[i] == v :
						op == OP_EXISTS ? (tbl_key[i] == k && tbl_val[i] == v) :
						tbl_key[i] == k)
					found = i;
			if (found < 0) begin
				res.push_back('{ST_MISS, '0, '0, 1'b1});
			end else begin
				res.push_back('{ST_OK, tbl_key[found], tbl_val[found], 1'b1});
				if (op == OP_REMOVE) begin
					// shift later entries down one place
					for (int j = found; j + 1 < tbl_count; j++) begin
						tbl_key[j] = tbl_key[j + 1];
						tbl_val[j] = tbl_val[j + 1];
					end
					tbl_count--;
				end
			end
		end
		OP_DEDUPE: begin
			// keep the first occurrence of each pair, in order
			kept = 0;
			for (int i = 0; i < tbl_count; i++) begin
				dup = 1'b0;
				for (int j = 0; j < kept; j++)
					if (tbl_key[j] == tbl_key[i] && tbl_val[j] == tbl_val[i])
						dup = 1'b1;
				if (!dup) begin
					tbl_key[kept] = tbl_key[i];
					tbl_val[kept] = tbl_val[i];
					kept++;
				end
			end
			tbl_count = kept;
			res.push_back('{ST_OK, '0, '0, 1'b1});
		end
		OP_DUMP: begin
			if (tbl_count == 0)
				res.push_back('{ST_MISS, '0, '0, 1'b1});
			for (int i = 0; i < tbl_count; i++)
				res.push_back('{ST_OK, tbl_key[i], tbl_val[i], i == tbl_count - 1});
		end
		default: begin
			res.push_back('{ST_MISS, '0, '0, 1'b1});
		end
		endcase
	endtask

	// Offer one request after an optional gap, hold it until accepted, then predict
	task automatic send_request(input op_t op, input logic [KEY_W-1:0] k,
			input logic signed [VAL_W-1:0] v, input int gap, input bit typed,
			input status_t typed_status);
		kv_result_t predicted [$];
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		key <= k;
		value <= v;
		do @(posedge clk); while (in_ready !== 1'b1);
		predict_table(op, k, v, predicted);
		requests_sent++;
		if (predicted[0].status == ST_FULL)
			full_refusals++;
		if (op == OP_DUMP && predicted.size() > largest_dump)
			largest_dump = predicted.size();
		if (typed)
			expected_results.push_back('{typed_status, '0, '0, 1'b1});
		else
			foreach (predicted[i]) expected_results.push_back(predicted[i]);
	endtask

	// Compare an accepted result against the oldest expectation
	task automatic check_result();
		kv_result_t exp_res;
		results_checked++;
		if (expected_results.size() == 0) begin
			$error("unexpected result: status %0d key %0h value %0d last %0b",
				status, out_key, out_value, last);
			fail_count++;
		end else begin
			exp_res = expected_results.pop_front();
			if (status !== exp_res.status) begin
				$error("status: expected %0d, got %0d", exp_res.status, status);
				fail_count++;
			end
			if (out_key !== exp_res.key) begin
				$error("out_key: expected %0h, got %0h", exp_res.key, out_key);
				fail_count++;
			end
			if (out_value !== exp_res.value) begin
				$error("out_value: expected %0d, got %0d", exp_res.value, out_value);
				fail_count++;
			end
			if (last !== exp_res.last) begin
				$error("last: expected %0b, got %0b", exp_res.last, last);
				fail_count++;
			end
		end
	endtask

	// Receive side: check results, stall at random, hold off on request
	initial begin
		int hold_left;
		bit hold_seen;
		hold_left = 0;
		hold_seen = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_ready)
				check_result();
			if (hold_toggle != hold_seen) begin
				hold_seen = hold_toggle;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Send side: reset, directed rows, random phases, drain
	initial begin
		op_t op;
		logic [KEY_W-1:0] k;
		logic signed [VAL_W-1:0] v;
		int gap;
		int r;
		int idx;
		int append_pct;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			send_request(directed_rows[i].op, directed_rows[i].key, directed_rows[i].value,
				0, directed_rows[i].typed, directed_rows[i].status);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			tx_idle_pct = PH_TX_IDLE[ph];
			rx_stall_pct <= PH_RX_STALL[ph];
			if (PH_HOLD[ph])
				hold_toggle <= ~hold_toggle;
			for (int n = 0; n < PH_COUNT[ph]; n++) begin
				// lean on appends until the table has filled
				append_pct = !PH_FILL[ph] ? 35 : (tbl_count < DEPTH) ? 95 : 50;
				if ($urandom_range(99) < append_pct) begin
					op = OP_APPEND;
				end else begin
					case ($urandom_range(12))
					0, 1:    op = OP_FIND_KEY;
					2, 3:    op = OP_FIND_VAL;
					4, 5:    op = OP_EXISTS;
					6, 7, 8: op = OP_REMOVE;
					9:       op = OP_DEDUPE;
					10, 11:  op = OP_DUMP;
					default: op = OP_NOP;
					endcase
				end

				// reuse stored pairs for hits and duplicates, else draw fresh ones
				if (tbl_count > 0 && $urandom_range(99) < 55) begin
					idx = $urandom_range(tbl_count - 1);
					k = tbl_key[idx];
					v = tbl_val[idx];
					r = $urandom_range(7);
					if (r == 0)
						k = k ^ 8'h01;
					else if (r == 1)
						v = v + 1;
				end else begin
					case ($urandom_range(3))
					0:       k = KEY_W'($urandom_range(7));
					1:       k = $urandom_range(1) ? 8'hff : 8'h00;
					default: k = KEY_W'($urandom);
					endcase
					case ($urandom_range(4))
					0:       v = $urandom_range(3);
					1:       v = -1;
					2:       v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
					default: v = $urandom;
					endcase
				end

				gap = 0;
				while (gap < 16 && $urandom_range(99) < tx_idle_pct)
					gap++;
				send_request(op, k, v, gap, 1'b0, ST_OK);
			end
		end
		in_valid <= 1'b0;

		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (2 * DEPTH + 8) @(posedge clk);

		$display("Ran %0d requests through the table, %0d results checked.",
			requests_sent, results_checked);
		$display("Saw %0d appends refused on a full table; largest dump %0d entries.",
			full_refusals, largest_dump);
		if (fail_count == 0)
			$display("key_value_table_linear_match_tb: PASS");
		else
			$display("key_value_table_linear_match_tb: FAIL");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
sv/kvt_pkg.sv
sv/kvt_cell.sv
sv/key_value_table_linear_match.sv
tb/sv/key_value_table_linear_match_tb.sv
